>>> design/whp_pkg.sv
// Package for the WAV header parser: phase and error codes, chunk tags,
// parser state and result types, and the per-phase field length table.
// No dependencies.
package whp_pkg;

  // Chunk tags as little-endian 32-bit words.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_PCM       = 32'd1;
  localparam logic [31:0] BITS_8        = 32'd8;
  localparam logic [31:0] BITS_16       = 32'd16;
  localparam logic [31:0] FMT_BASE_SIZE = 32'd16;

  localparam logic [1:0] SBYTES_NONE = 2'd0;
  localparam logic [1:0] SBYTES_8    = 2'd1;
  localparam logic [1:0] SBYTES_16   = 2'd2;

  typedef enum logic [3:0] {
    PH_RIFF      = 4'd0,
    PH_RIFFSIZE  = 4'd1,
    PH_WAVE      = 4'd2,
    PH_FMTTAG    = 4'd3,
    PH_FMTSIZE   = 4'd4,
    PH_FORMAT    = 4'd5,
    PH_CHANNELS  = 4'd6,
    PH_RATE      = 4'd7,
    PH_BYTERATE  = 4'd8,
    PH_ALIGN     = 4'd9,
    PH_BITS      = 4'd10,
    PH_CHUNKID   = 4'd11,
    PH_OTHERSIZE = 4'd12,
    PH_DATASIZE  = 4'd13,
    PH_SKIP      = 4'd14,
    PH_PAYLOAD   = 4'd15
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_RIFF     = 3'd1,
    ERR_WAVE     = 3'd2,
    ERR_FMT_TAG  = 3'd3,
    ERR_FORMAT   = 3'd4,
    ERR_BITS     = 3'd5,
    ERR_FMT_SIZE = 3'd6,
    ERR_NO_DATA  = 3'd7
  } err_t;

  typedef struct packed {
    phase_t      phase;
    logic [2:0]  field_offset;
    logic [31:0] field_acc;
    logic [31:0] skip_remaining;
    logic [31:0] format_size;
    logic [15:0] channels;
    logic [31:0] rate;
    logic [1:0]  sample_bytes;
    logic [31:0] data_size;
    err_t        err;
  } whp_state_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        header_ready;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [1:0]  bytes_per_sample;
    logic [31:0] data_size;
    logic [2:0]  error_code;
  } whp_result_t;

  localparam whp_state_t STATE_RESET = '{
    phase:          PH_RIFF,
    field_offset:   3'd0,
    field_acc:      32'd0,
    skip_remaining: 32'd0,
    format_size:    32'd0,
    channels:       16'd0,
    rate:           32'd0,
    sample_bytes:   SBYTES_NONE,
    data_size:      32'd0,
    err:            ERR_NONE
  };

  // Number of bytes in the header field collected during each phase.
  function automatic logic [2:0] field_len(phase_t ph);
    logic [2:0] len;
    unique case (ph)
      PH_FORMAT, PH_CHANNELS, PH_ALIGN, PH_BITS: len = 3'd2;
      PH_SKIP, PH_PAYLOAD:                       len = 3'd0;
      default:                                   len = 3'd4;
    endcase
    return len;
  endfunction

endpackage

>>> design/whp_if.sv
// Valid/ready channel interfaces for the WAV header parser.
// Depends on nothing; payload widths follow the parser's item fields.
interface whp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;

  modport source (output valid, data_byte, first, last, input ready);
  modport sink   (input valid, data_byte, first, last, output ready);
endinterface

interface whp_out_if;
  logic        valid;
  logic        ready;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic        header_ready;
  logic [15:0] channel_count;
  logic [31:0] sample_rate;
  logic [1:0]  bytes_per_sample;
  logic [31:0] data_size;
  logic [2:0]  error_code;

  modport source (output valid, payload_valid, payload_byte, header_ready, channel_count,
                  sample_rate, bytes_per_sample, data_size, error_code, input ready);
  modport sink   (input valid, payload_valid, payload_byte, header_ready, channel_count,
                  sample_rate, bytes_per_sample, data_size, error_code, output ready);
endinterface

>>> design/wav_header_parser_core.sv
// Top level of the WAV header parser: parser state register, result register
// and channel handshake. Depends on whp_pkg, whp_if and whp_step.
//
//  Channel | Direction | Payload
//  --------+-----------+-------------------------------------------------------
//  in_ch   | in        | data_byte, first, last
//  out_ch  | out       | payload_valid, payload_byte, header_ready, channel_count,
//          |           | sample_rate, bytes_per_sample, data_size, error_code
//
// Each accepted byte yields one result item, registered and shown on out_ch in the
// next cycle; the block takes one byte per cycle while out_ch is not stalled. Reset
// is synchronous and returns the parser to the RIFF tag. While a result waits on
// out_ch, a new byte is still taken if the result is taken in the same cycle.
module wav_header_parser_core (
  input  logic             clk,
  input  logic             rst_n,
  whp_in_if.sink           in_ch,
  whp_out_if.source        out_ch
);
  import whp_pkg::*;

  whp_state_t  state_r;
  whp_state_t  state_nxt;
  whp_result_t res_r;
  whp_result_t res_nxt;
  logic        out_valid_r;
  logic        in_accept;

  // Take a byte whenever the result register is empty or being drained.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_accept   = in_ch.valid && in_ch.ready;

  whp_step u_step (
    .state_cur (state_r),
    .data_byte (in_ch.data_byte),
    .first     (in_ch.first),
    .last      (in_ch.last),
    .state_nxt (state_nxt),
    .res_nxt   (res_nxt)
  );

  // Parser state advances once per accepted item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.payload_valid    = res_r.payload_valid;
  assign out_ch.payload_byte     = res_r.payload_byte;
  assign out_ch.header_ready     = res_r.header_ready;
  assign out_ch.channel_count    = res_r.channel_count;
  assign out_ch.sample_rate      = res_r.sample_rate;
  assign out_ch.bytes_per_sample = res_r.bytes_per_sample;
  assign out_ch.data_size        = res_r.data_size;
  assign out_ch.error_code       = res_r.error_code;

  // An accepted item always produces a result on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) in_accept |=> out_valid_r)
    else $error("accepted item produced no result");

  // Payload bytes only flow with no error and never on the header byte.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.payload_valid) |-> (res_r.error_code == ERR_NONE
                                              && !res_r.header_ready))
    else $error("payload item with error or header flag");

  // A latched error freezes the phase until a byte marked first.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.err != ERR_NONE && !(in_accept && in_ch.first)) |=> $stable(state_r.phase))
    else $error("phase moved while an error was latched");

  // Header ready is reported only as the parser enters the payload phase.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && res_nxt.header_ready) |=> (state_r.phase == PH_PAYLOAD))
    else $error("header ready without entering payload phase");

endmodule

>>> design/whp_step.sv
// Combinational next-state and result logic for one input byte of the parser.
// Depends on whp_pkg.
module whp_step (
  input  whp_pkg::whp_state_t  state_cur,
  input  logic [7:0]           data_byte,
  input  logic                 first,
  input  logic                 last,
  output whp_pkg::whp_state_t  state_nxt,
  output whp_pkg::whp_result_t res_nxt
);
  import whp_pkg::*;

  whp_state_t  s;
  whp_state_t  n;
  logic [31:0] acc_new;
  logic [2:0]  off_inc;
  logic [31:0] fmt_extra;
  logic        pv;
  logic [7:0]  pb;
  logic        hr;

  assign fmt_extra = s.format_size - FMT_BASE_SIZE;

  always_comb begin
    // A byte marked first restarts the parser before it is consumed.
    s = first ? STATE_RESET : state_cur;
    n = s;
    pv = 1'b0;
    pb = 8'd0;
    hr = 1'b0;
    acc_new = s.field_acc;
    off_inc = s.field_offset + 3'd1;

    // Merge this byte into the little-endian field word.
    unique case (s.field_offset[1:0])
      2'd0: acc_new = s.field_acc | {24'd0, data_byte};
      2'd1: acc_new = s.field_acc | {16'd0, data_byte, 8'd0};
      2'd2: acc_new = s.field_acc | {8'd0, data_byte, 16'd0};
      2'd3: acc_new = s.field_acc | {data_byte, 24'd0};
      default: acc_new = s.field_acc;
    endcase

    if (s.err == ERR_NONE) begin
      if (s.phase == PH_PAYLOAD) begin
        pv = 1'b1;
        pb = data_byte;
      end else if (s.phase == PH_SKIP) begin
        // Count down the chunk body, then drop the pad byte if one is owed.
        if (s.skip_remaining != 32'd0) begin
          n.skip_remaining = s.skip_remaining - 32'd1;
        end else begin
          n.field_offset = 3'd0;
        end
        if (n.skip_remaining == 32'd0 && n.field_offset == 3'd0) begin
          n.phase = PH_CHUNKID;
        end
      end else if (off_inc < field_len(s.phase)) begin
        n.field_acc = acc_new;
        n.field_offset = off_inc;
      end else begin
        // Field complete: act on its value.
        n.field_acc = 32'd0;
        n.field_offset = 3'd0;
        unique case (s.phase)
          PH_RIFF: begin
            if (acc_new != TAG_RIFF) n.err = ERR_RIFF;
            else n.phase = PH_RIFFSIZE;
          end
          PH_RIFFSIZE: n.phase = PH_WAVE;
          PH_WAVE: begin
            if (acc_new != TAG_WAVE) n.err = ERR_WAVE;
            else n.phase = PH_FMTTAG;
          end
          PH_FMTTAG: begin
            if (acc_new != TAG_FMT) n.err = ERR_FMT_TAG;
            else n.phase = PH_FMTSIZE;
          end
          PH_FMTSIZE: begin
            n.format_size = acc_new;
            n.phase = PH_FORMAT;
          end
          PH_FORMAT: begin
            if (acc_new != FMT_PCM) n.err = ERR_FORMAT;
            else n.phase = PH_CHANNELS;
          end
          PH_CHANNELS: begin
            n.channels = acc_new[15:0];
            n.phase = PH_RATE;
          end
          PH_RATE: begin
            n.rate = acc_new;
            n.phase = PH_BYTERATE;
          end
          PH_BYTERATE: n.phase = PH_ALIGN;
          PH_ALIGN:    n.phase = PH_BITS;
          PH_BITS: begin
            // Sample width is checked before the format size.
            if (acc_new == BITS_8 || acc_new == BITS_16) begin
              n.sample_bytes = (acc_new == BITS_8) ? SBYTES_8 : SBYTES_16;
              if (s.format_size < FMT_BASE_SIZE) begin
                n.err = ERR_FMT_SIZE;
              end else begin
                // Skip any extra format bytes plus a pad byte on odd sizes.
                n.skip_remaining = fmt_extra;
                n.field_offset = {2'd0, s.format_size[0]};
                n.phase = (fmt_extra == 32'd0 && !s.format_size[0]) ? PH_CHUNKID : PH_SKIP;
              end
            end else begin
              n.err = ERR_BITS;
            end
          end
          PH_CHUNKID: n.phase = (acc_new == TAG_DATA) ? PH_DATASIZE : PH_OTHERSIZE;
          PH_OTHERSIZE: begin
            n.skip_remaining = acc_new;
            n.field_offset = {2'd0, acc_new[0]};
            n.phase = (acc_new == 32'd0) ? PH_CHUNKID : PH_SKIP;
          end
          PH_DATASIZE: begin
            n.data_size = acc_new;
            n.phase = PH_PAYLOAD;
            hr = 1'b1;
          end
          default: n.phase = s.phase;
        endcase
      end

      // A stream that ends before the payload is flagged.
      if (last && n.err == ERR_NONE && n.phase != PH_PAYLOAD) begin
        n.err = ERR_NO_DATA;
      end
    end

    state_nxt = n;
    res_nxt.payload_valid    = pv;
    res_nxt.payload_byte     = pb;
    res_nxt.header_ready     = hr;
    res_nxt.channel_count    = n.channels;
    res_nxt.sample_rate      = n.rate;
    res_nxt.bytes_per_sample = n.sample_bytes;
    res_nxt.data_size        = n.data_size;
    res_nxt.error_code       = n.err;
  end

endmodule

>>> tb/tb_wav_header_parser_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for wav_header_parser_core: byte-level WAV streams in, results
// checked field by field against a cycle-free parser written here. Depends on whp_pkg,
// whp_if and the parser RTL.
module tb_wav_header_parser_core;
  import whp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1350;
  localparam int IDLE_PCT     = 27;
  localparam int HOLD_CYCLES  = 300;
  localparam int END_CYCLES   = 10;

  // Shapes of generated files.
  typedef enum int {
    FILE_GOOD,
    FILE_BAD_RIFF,
    FILE_BAD_WAVE,
    FILE_BAD_FMT,
    FILE_BAD_FORMAT,
    FILE_BAD_BITS,
    FILE_SHORT_FMT,
    FILE_TRUNCATED,
    FILE_STRAY_LAST,
    FILE_NOISE
  } file_kind_t;

  // Tracks the parser state, keeps the results owed by the block and checks them.
  class wav_parse_board;
    phase_t      phase;
    logic [2:0]  offset;     // Byte position in a field, or the pad flag while skipping.
    logic [31:0] acc;
    logic [31:0] skip_left;
    logic [31:0] fmt_size;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [1:0]  sbytes;
    logic [31:0] dsize;
    err_t        err;
    whp_result_t parsed_results[$];
    int          failures;

    function new();
      restart();
      failures = 0;
    endfunction

    function void restart();
      phase     = PH_RIFF;
      offset    = 3'd0;
      acc       = 32'd0;
      skip_left = 32'd0;
      fmt_size  = 32'd0;
      chans     = 16'd0;
      rate      = 32'd0;
      sbytes    = SBYTES_NONE;
      dsize     = 32'd0;
      err       = ERR_NONE;
    endfunction

    // Two-byte fields are the short words of the format chunk; all others are words.
    function int field_bytes(phase_t p);
      case (p)
        PH_FORMAT, PH_CHANNELS, PH_ALIGN, PH_BITS: return 2;
        default: return 4;
      endcase
    endfunction

    function void begin_skip(logic [31:0] n, logic pad);
      skip_left = n;
      offset    = {2'b00, pad};
      phase     = (n == 32'd0 && !pad) ? PH_CHUNKID : PH_SKIP;
    endfunction

    // Acts on a completed header field. Returns 1 when the data chunk header is done.
    function logic close_field(logic [31:0] v);
      logic done;
      done = 1'b0;
      case (phase)
        PH_RIFF:      if (v != TAG_RIFF) err = ERR_RIFF; else phase = PH_RIFFSIZE;
        PH_RIFFSIZE:  phase = PH_WAVE;
        PH_WAVE:      if (v != TAG_WAVE) err = ERR_WAVE; else phase = PH_FMTTAG;
        PH_FMTTAG:    if (v != TAG_FMT) err = ERR_FMT_TAG; else phase = PH_FMTSIZE;
        PH_FMTSIZE: begin
          fmt_size = v;
          phase    = PH_FORMAT;
        end
        PH_FORMAT:    if (v != FMT_PCM) err = ERR_FORMAT; else phase = PH_CHANNELS;
        PH_CHANNELS: begin
          chans = v[15:0];
          phase = PH_RATE;
        end
        PH_RATE: begin
          rate  = v;
          phase = PH_BYTERATE;
        end
        PH_BYTERATE:  phase = PH_ALIGN;
        PH_ALIGN:     phase = PH_BITS;
        PH_BITS: begin
          // Bits are judged before the format size, so a bad width wins.
          if (v == BITS_8 || v == BITS_16) begin
            sbytes = (v == BITS_8) ? SBYTES_8 : SBYTES_16;
            if (fmt_size < FMT_BASE_SIZE) err = ERR_FMT_SIZE;
            else begin_skip(fmt_size - FMT_BASE_SIZE, fmt_size[0]);
          end else begin
            err = ERR_BITS;
          end
        end
        PH_CHUNKID:   phase = (v == TAG_DATA) ? PH_DATASIZE : PH_OTHERSIZE;
        PH_OTHERSIZE: begin_skip(v, v[0]);
        PH_DATASIZE: begin
          dsize = v;
          phase = PH_PAYLOAD;
          done  = 1'b1;
        end
        default: ;
      endcase
      return done;
    endfunction

    // Advances the parser by one byte and returns the result that byte causes.
    function whp_result_t parse_byte(logic [7:0] b, logic first, logic last);
      whp_result_t r;
      logic [31:0] word;
      r = '0;
      if (first) restart();
      if (err == ERR_NONE) begin
        if (phase == PH_PAYLOAD) begin
          r.payload_valid = 1'b1;
          r.payload_byte  = b;
        end else if (phase == PH_SKIP) begin
          // The pad byte of an odd chunk is eaten once the count reaches zero.
          if (skip_left != 32'd0) skip_left = skip_left - 32'd1;
          else offset = 3'd0;
          if (skip_left == 32'd0 && offset == 3'd0) phase = PH_CHUNKID;
        end else begin
          acc    = acc | ({24'd0, b} << (8 * offset[1:0]));
          offset = offset + 3'd1;
          if (offset >= field_bytes(phase)) begin
            word   = acc;
            acc    = 32'd0;
            offset = 3'd0;
            r.header_ready = close_field(word);
          end
        end
        if (last && err == ERR_NONE && phase != PH_PAYLOAD) err = ERR_NO_DATA;
      end
      r.channel_count    = chans;
      r.sample_rate      = rate;
      r.bytes_per_sample = sbytes;
      r.data_size        = dsize;
      r.error_code       = err;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic first, logic last);
      parsed_results.push_back(parse_byte(b, first, last));
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    function void check_output(whp_result_t got);
      whp_result_t want;
      if (parsed_results.size() == 0) begin
        $error("Result item arrived while none was expected");
        failures++;
        return;
      end
      want = parsed_results.pop_front();
      check_field("payload_valid", want.payload_valid, got.payload_valid);
      check_field("payload_byte", want.payload_byte, got.payload_byte);
      check_field("header_ready", want.header_ready, got.header_ready);
      check_field("channel_count", want.channel_count, got.channel_count);
      check_field("sample_rate", want.sample_rate, got.sample_rate);
      check_field("bytes_per_sample", want.bytes_per_sample, got.bytes_per_sample);
      check_field("data_size", want.data_size, got.data_size);
      check_field("error_code", want.error_code, got.error_code);
    endfunction

    function int backlog();
      return parsed_results.size();
    endfunction

    function void final_check();
      if (parsed_results.size() != 0) begin
        $error("%0d expected result items never arrived", parsed_results.size());
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  whp_in_if  in_bus();
  whp_out_if out_bus();

  wav_header_parser_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  wav_parse_board board = new();

  bit         src_idle_on  = 1'b1;
  bit         sink_idle_on = 1'b1;
  bit         hold_req     = 1'b0;
  int         hold_left    = 0;
  int         items_sent   = 0;
  int         cycle_count  = 0;
  logic [7:0] file_bytes[$];

  // 20 ns clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Give up on a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Every accepted input item updates the parser and queues its result.
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      board.note_byte(in_bus.data_byte, in_bus.first, in_bus.last);
  end

  // Every accepted result item is checked against the oldest queued one.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      board.check_output('{payload_valid:    out_bus.payload_valid,
                           payload_byte:     out_bus.payload_byte,
                           header_ready:     out_bus.header_ready,
                           channel_count:    out_bus.channel_count,
                           sample_rate:      out_bus.sample_rate,
                           bytes_per_sample: out_bus.bytes_per_sample,
                           data_size:        out_bus.data_size,
                           error_code:       out_bus.error_code});
    end
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= !sink_idle_on || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one byte, idling first at random, and returns once it is taken.
  task automatic put_byte(input logic [7:0] b, input logic f, input logic l);
    while (src_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.first     <= f;
    in_bus.last      <= l;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    items_sent++;
  endtask

  // Stops offering until every queued result has come out. The item taken at the
  // current edge may not be queued yet, so the backlog is read from the next edge on.
  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.backlog() != 0) @(posedge clk);
  endtask

  task automatic push_le(ref logic [7:0] q[$], input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) q.push_back(v[8*i +: 8]);
  endtask

  task automatic flip_bit(ref logic [7:0] q[$], input int idx);
    q[idx] = q[idx] ^ 8'(1 << $urandom_range(7));
  endtask

  // Field values lean toward the extremes now and then.
  function automatic logic [31:0] pick32();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Builds one file: a well-formed header with random content, then the chosen fault.
  task automatic build_wav(ref logic [7:0] q[$], input file_kind_t kind);
    logic [31:0] fsize;
    logic [31:0] csize;
    logic [31:0] id;
    int          nchunks;
    int          cut;
    bit          open_end;
    q.delete();
    open_end = 1'b0;
    if (kind == FILE_NOISE) begin
      repeat ($urandom_range(12, 1)) q.push_back(8'($urandom));
      return;
    end
    fsize = FMT_BASE_SIZE;
    if (kind == FILE_SHORT_FMT) fsize = $urandom_range(15);
    else if ($urandom_range(3) == 0) fsize = FMT_BASE_SIZE + $urandom_range(7, 1);
    push_le(q, TAG_RIFF, 4);
    push_le(q, pick32(), 4);
    push_le(q, TAG_WAVE, 4);
    push_le(q, TAG_FMT, 4);
    push_le(q, fsize, 4);
    push_le(q, FMT_PCM, 2);
    push_le(q, pick32(), 2);
    push_le(q, pick32(), 4);
    push_le(q, $urandom, 4);
    push_le(q, $urandom, 2);
    push_le(q, $urandom_range(1) ? BITS_16 : BITS_8, 2);
    // Extra format bytes, plus the pad byte when the format size is odd.
    if (fsize > FMT_BASE_SIZE)
      repeat (fsize - FMT_BASE_SIZE + fsize[0]) q.push_back(8'($urandom));
    // Up to two foreign chunks; a huge one leaves the file ending inside it.
    nchunks = $urandom_range(2);
    for (int c = 0; c < nchunks && !open_end; c++) begin
      id = $urandom;
      if (id == TAG_DATA) id = id ^ 32'h1;
      push_le(q, id, 4);
      if ($urandom_range(15) == 0) begin
        csize = $urandom | 32'h100;
        push_le(q, csize, 4);
        repeat (3) q.push_back(8'($urandom));
        open_end = 1'b1;
      end else begin
        csize = $urandom_range(9);
        push_le(q, csize, 4);
        repeat (csize + csize[0]) q.push_back(8'($urandom));
      end
    end
    if (!open_end) begin
      push_le(q, TAG_DATA, 4);
      push_le(q, pick32(), 4);
      repeat ($urandom_range(16)) q.push_back(8'($urandom));
    end
    case (kind)
      FILE_BAD_RIFF:   flip_bit(q, $urandom_range(3));
      FILE_BAD_WAVE:   flip_bit(q, 8 + $urandom_range(3));
      FILE_BAD_FMT:    flip_bit(q, 12 + $urandom_range(3));
      FILE_BAD_FORMAT: flip_bit(q, 20 + $urandom_range(1));
      FILE_BAD_BITS:   flip_bit(q, 34 + $urandom_range(1));
      FILE_TRUNCATED: begin
        cut = $urandom_range(43, 1);
        while (q.size() > cut) q.pop_back();
      end
      default: ;
    endcase
  endtask

  // Sends a file: first on byte zero, last at the given index (none if negative).
  // Noisy files get random first and last markers instead.
  task automatic send_file(ref logic [7:0] q[$], input int last_at, input bit noisy);
    logic f;
    logic l;
    for (int i = 0; i < q.size(); i++) begin
      f = (i == 0);
      l = (i == last_at);
      if (noisy) begin
        f = ($urandom_range(3) == 0);
        l = ($urandom_range(3) == 0);
      end
      put_byte(q[i], f, l);
    end
  endtask

  // Reset, directed cases, random files, then the final verdict.
  initial begin
    file_kind_t kind;
    int         pick;
    int         file_no;
    int         last_at;
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.data_byte <= 8'd0;
    in_bus.first     <= 1'b0;
    in_bus.last      <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A RIFF tag with a wrong fourth letter, then a byte marked last that is ignored.
    file_bytes.delete();
    push_le(file_bytes, TAG_RIFF ^ 32'h1E00_0000, 4);
    send_file(file_bytes, -1, 1'b0);
    put_byte(8'hFF, 1'b0, 1'b1);

    // A file of one byte, marked both first and last, ends before any data chunk.
    put_byte(8'h00, 1'b1, 1'b1);

    // A good RIFF tag with an all-ones size, followed by a broken WAVE tag.
    file_bytes.delete();
    push_le(file_bytes, TAG_RIFF, 4);
    push_le(file_bytes, '1, 4);
    push_le(file_bytes, TAG_WAVE ^ 32'h8000_0000, 4);
    send_file(file_bytes, -1, 1'b0);

    // Random files, mostly well formed.
    file_no = 0;
    while (items_sent < RANDOM_ITEMS + 18) begin
      file_no++;
      if (file_no == 6) hold_req = 1'b1;
      if (file_no == 12 || $urandom_range(11) == 0) wait_for_results();
      src_idle_on  = !(file_no >= 16 && file_no <= 20);
      sink_idle_on = src_idle_on;
      pick = $urandom_range(99);
      if (pick < 55)      kind = FILE_GOOD;
      else if (pick < 60) kind = FILE_BAD_RIFF;
      else if (pick < 64) kind = FILE_BAD_WAVE;
      else if (pick < 68) kind = FILE_BAD_FMT;
      else if (pick < 73) kind = FILE_BAD_FORMAT;
      else if (pick < 78) kind = FILE_BAD_BITS;
      else if (pick < 83) kind = FILE_SHORT_FMT;
      else if (pick < 90) kind = FILE_TRUNCATED;
      else if (pick < 94) kind = FILE_STRAY_LAST;
      else                kind = FILE_NOISE;
      build_wav(file_bytes, kind);
      if (kind == FILE_STRAY_LAST) last_at = $urandom_range(file_bytes.size() - 1);
      else if ($urandom_range(9) == 0) last_at = -1;
      else last_at = file_bytes.size() - 1;
      send_file(file_bytes, last_at, kind == FILE_NOISE);
      // Bytes after the end of a file, without first, continue the same stream.
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(4, 1)) put_byte(8'($urandom), 1'b0, 1'($urandom_range(1)));
    end

    wait_for_results();
    repeat (END_CYCLES) @(posedge clk);
    board.final_check();
    if (board.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
